### design/dcaas_pkg.sv
package dcaas_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int SUM_W     = 14;
  localparam int CNT_W     = 6;
  localparam int LEVEL_W   = 14;
  localparam int TEMP_W    = 16;

  localparam int SCALE_W   = 6;
  localparam int ZERO_W    = 12;
  localparam int SLOPE_W   = 10;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_ADDR_W-1:0] REG_BATTERY_SCALE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFFSET_MV = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOPE_CENTI_MV = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST = 6'd44;
  localparam logic [ZERO_W-1:0]  ZERO_RST  = 12'd968;
  localparam logic [SLOPE_W-1:0] SLOPE_RST = 10'd247;

  localparam int AVERAGE_LEN_DEF = 10;

  // Serial multiplier operands and product.
  localparam int MUL_A_W   = 20;
  localparam int MUL_B_W   = 14;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Serial divider operands.
  localparam int DVD_W     = 30;
  localparam int DVS_W     = 10;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam int MV_W      = 20;
  localparam int MV_SHIFT  = 8;
  localparam int KILO      = 1000;

  localparam logic [TEMP_W-1:0] TEMP_MAX = 16'h7fff;
  localparam logic [TEMP_W-1:0] TEMP_MIN = 16'h8000;
  localparam int SAT_NEG_MAG = 32768;

  localparam int OUT_TDATA_W = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### design/dual_channel_adc_average_scaler_core.sv
// Averages 8-bit conversion words that alternate battery, temperature, battery, ...
// and turns the averages into battery millivolts and temperature in tenths of a
// degree. Every input word gives one output word. A word that only adds to a sum
// passes through the EMIT state, which loads the output register once it is empty
// or being taken, and the input is ready again when EMIT is done. A battery word
// that closes an averaging run goes through a 30-step serial divide by the run
// length, then a 14-step shift-add multiply by the scale; a temperature word that
// closes a run goes through a divide, a multiply by the battery level, a
// zero-offset subtraction, a multiply by 1000, then a 30-step divide by the
// slope, and it sets conv_done.
// The input takes a new word once the previous one has reached the output
// register, even if that word has not yet been taken.
module dual_channel_adc_average_scaler_core #(
  parameter int AVERAGE_LEN = dcaas_pkg::AVERAGE_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // sample [7:0]
  input  logic [dcaas_pkg::SAMPLE_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // next_channel [0], battery_mv [14:1], temperature_dc [30:15], zero [31]
  output logic [dcaas_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // conv_done [0]
  output logic                                 out_tuser,
  input  logic                                 cfg_we,
  input  logic [dcaas_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dcaas_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dcaas_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BDIV = 3'd1;
  localparam logic [2:0] ST_BMUL = 3'd2;
  localparam logic [2:0] ST_TDIV = 3'd3;
  localparam logic [2:0] ST_TMUL = 3'd4;
  localparam logic [2:0] ST_NMUL = 3'd5;
  localparam logic [2:0] ST_SDIV = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  localparam logic [DVS_W-1:0] AVG_DIV = (AVERAGE_LEN == 0) ? DVS_W'(1) : DVS_W'(AVERAGE_LEN);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(AVERAGE_LEN);

  logic [2:0]              state_r, state_nxt;
  logic [SCALE_W-1:0]      scale_r, scale_nxt;
  logic [ZERO_W-1:0]       zero_r, zero_nxt;
  logic [SLOPE_W-1:0]      slope_r, slope_nxt;
  logic                    ch_r, ch_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SUM_W-1:0]        bsum_r, bsum_nxt;
  logic [SUM_W-1:0]        tsum_r, tsum_nxt;
  logic [LEVEL_W-1:0]      blevel_r, blevel_nxt;
  logic [TEMP_W-1:0]       tlevel_r, tlevel_nxt;
  logic                    done_r, done_nxt;
  logic [SUM_W-1:0]        avg_r, avg_nxt;
  logic [MV_W-1:0]         mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [DVD_W-1:0]        num_r, num_nxt;
  logic                    mul_go_r, mul_go_nxt;
  logic                    div_go_r, div_go_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic                    out_tuser_r, out_tuser_nxt;

  logic                    accept;
  logic                    full;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       mul_prod;
  unit_stat_t              mul_stat;
  logic [DVD_W-1:0]        div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  logic [DVD_W-1:0]        div_quot;
  unit_stat_t              div_stat;
  logic [SLOPE_W-1:0]      slope_eff;
  logic [MV_W-1:0]         mv;
  logic [MV_W:0]           diff;
  logic [MV_W:0]           diff_abs;
  logic                    pos_big;
  logic                    neg_big;
  logic [TEMP_W-1:0]       temp_sat;

  assign accept    = in_tvalid && in_tready;
  assign full      = (cnt_r == CNT_FULL);
  assign slope_eff = (slope_r == '0) ? SLOPE_W'(1) : slope_r;

  assign mv       = mul_prod[MV_SHIFT +: MV_W];
  assign diff     = {1'b0, mv} - (MV_W + 1)'(zero_r);
  assign diff_abs = diff[MV_W] ? (~diff + 1'b1) : diff;

  assign pos_big  = |div_quot[DVD_W-1:TEMP_W-1];
  assign neg_big  = (div_quot > DVD_W'(SAT_NEG_MAG));

  always_comb begin
    if (neg_r) begin
      temp_sat = neg_big ? TEMP_MIN : TEMP_W'(~div_quot[TEMP_W-1:0] + 1'b1);
    end else begin
      temp_sat = pos_big ? TEMP_MAX : div_quot[TEMP_W-1:0];
    end
  end

  always_comb begin
    case (state_r)
      ST_BMUL: begin
        mul_a = MUL_A_W'(avg_r);
        mul_b = MUL_B_W'(scale_r);
      end
      ST_TMUL: begin
        mul_a = MUL_A_W'(avg_r);
        mul_b = MUL_B_W'(blevel_r);
      end
      ST_NMUL: begin
        mul_a = mag_r;
        mul_b = MUL_B_W'(KILO);
      end
      default: begin
        mul_a = MUL_A_W'(avg_r);
        mul_b = MUL_B_W'(scale_r);
      end
    endcase
  end

  always_comb begin
    case (state_r)
      ST_BDIV: begin
        div_dvd = DVD_W'(bsum_r);
        div_dvs = AVG_DIV;
      end
      ST_TDIV: begin
        div_dvd = DVD_W'(tsum_r);
        div_dvs = AVG_DIV;
      end
      ST_SDIV: begin
        div_dvd = num_r;
        div_dvs = DVS_W'(slope_eff);
      end
      default: begin
        div_dvd = num_r;
        div_dvs = AVG_DIV;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    scale_nxt      = scale_r;
    zero_nxt       = zero_r;
    slope_nxt      = slope_r;
    ch_nxt         = ch_r;
    cnt_nxt        = cnt_r;
    bsum_nxt       = bsum_r;
    tsum_nxt       = tsum_r;
    blevel_nxt     = blevel_r;
    tlevel_nxt     = tlevel_r;
    done_nxt       = done_r;
    avg_nxt        = avg_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    num_nxt        = num_r;
    mul_go_nxt     = 1'b0;
    div_go_nxt     = 1'b0;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    if (cfg_we) begin
      case (cfg_addr)
        REG_BATTERY_SCALE:  scale_nxt = cfg_wdata[SCALE_W-1:0];
        REG_ZERO_OFFSET_MV: zero_nxt  = cfg_wdata[ZERO_W-1:0];
        REG_SLOPE_CENTI_MV: slope_nxt = cfg_wdata[SLOPE_W-1:0];
        default: ;
      endcase
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          done_nxt = 1'b0;
          if (full) begin
            div_go_nxt = 1'b1;
            state_nxt  = ch_r ? ST_TDIV : ST_BDIV;
          end else begin
            if (ch_r) begin
              tsum_nxt = tsum_r + SUM_W'(in_tdata);
              cnt_nxt  = cnt_r + 1'b1;
            end else begin
              bsum_nxt = bsum_r + SUM_W'(in_tdata);
            end
            ch_nxt    = ~ch_r;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_BDIV: begin
        if (div_stat.done) begin
          avg_nxt    = div_quot[SUM_W-1:0];
          mul_go_nxt = 1'b1;
          state_nxt  = ST_BMUL;
        end
      end
      ST_BMUL: begin
        if (mul_stat.done) begin
          blevel_nxt = mul_prod[LEVEL_W-1:0];
          bsum_nxt   = '0;
          ch_nxt     = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      ST_TDIV: begin
        if (div_stat.done) begin
          avg_nxt    = div_quot[SUM_W-1:0];
          mul_go_nxt = 1'b1;
          state_nxt  = ST_TMUL;
        end
      end
      ST_TMUL: begin
        if (mul_stat.done) begin
          neg_nxt    = diff[MV_W];
          mag_nxt    = diff_abs[MV_W-1:0];
          mul_go_nxt = 1'b1;
          state_nxt  = ST_NMUL;
        end
      end
      ST_NMUL: begin
        if (mul_stat.done) begin
          num_nxt    = mul_prod[DVD_W-1:0];
          div_go_nxt = 1'b1;
          state_nxt  = ST_SDIV;
        end
      end
      ST_SDIV: begin
        if (div_stat.done) begin
          tlevel_nxt = temp_sat;
          tsum_nxt   = '0;
          cnt_nxt    = '0;
          ch_nxt     = 1'b0;
          done_nxt   = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, tlevel_r, blevel_r, ch_r};
          out_tuser_nxt  = done_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scale_r      <= SCALE_RST;
      zero_r       <= ZERO_RST;
      slope_r      <= SLOPE_RST;
      ch_r         <= 1'b0;
      cnt_r        <= '0;
      bsum_r       <= '0;
      tsum_r       <= '0;
      blevel_r     <= '0;
      tlevel_r     <= '0;
      done_r       <= 1'b0;
      mul_go_r     <= 1'b0;
      div_go_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scale_r      <= scale_nxt;
      zero_r       <= zero_nxt;
      slope_r      <= slope_nxt;
      ch_r         <= ch_nxt;
      cnt_r        <= cnt_nxt;
      bsum_r       <= bsum_nxt;
      tsum_r       <= tsum_nxt;
      blevel_r     <= blevel_nxt;
      tlevel_r     <= tlevel_nxt;
      done_r       <= done_nxt;
      mul_go_r     <= mul_go_nxt;
      div_go_r     <= div_go_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r       <= avg_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    num_r       <= num_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  dcaas_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  dcaas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef NO_ASSERTIONS
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy at the same time");

  a_accept_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!mul_stat.busy && !div_stat.busy))
    else $error("word accepted while an arithmetic unit is busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("sample count passed the averaging length");

  a_done_on_temperature: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[0] == 1'b0))
    else $error("conv_done on a word that was not a temperature close");
`endif

endmodule

### design/dcaas_mul.sv
module dcaas_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dcaas_pkg::MUL_A_W-1:0] a,
  input  logic [dcaas_pkg::MUL_B_W-1:0] b,
  output dcaas_pkg::unit_stat_t         stat,
  output logic [dcaas_pkg::PROD_W-1:0]  prod
);
  import dcaas_pkg::*;

  logic [PROD_W-1:0]    a_r, a_nxt;
  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic [MUL_B_W-1:0]   b_r, b_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = PROD_W'(a);
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = MUL_CNT_W'(MUL_B_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

### design/dcaas_div.sv
module dcaas_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dcaas_pkg::DVD_W-1:0]  dividend,
  input  logic [dcaas_pkg::DVS_W-1:0]  divisor,
  output dcaas_pkg::unit_stat_t         stat,
  output logic [dcaas_pkg::DVD_W-1:0]  quot
);
  import dcaas_pkg::*;

  logic [DVD_W-1:0]     q_r, q_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DVS_W:0]       trial;
  logic                 fits;

  assign trial = {rem_r, q_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(DVD_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DVS_W-1:0];
      end
      q_nxt   = {q_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule
